// ----- rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescape unit.
`default_nettype none

package jsu_pkg;

	// Input item: one raw byte of the escaped string body.
	typedef struct packed {
		logic [7:0] in_byte;
		logic       has_byte;
		logic       last_byte;
	} in_t;

	// Result item: one unescaped byte, end mark or error report.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
		logic [1:0] error_code;
	} out_t;

	// Work handed from the decoder to the output side: one to three result beats.
	typedef struct packed {
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
		logic            vld;
		logic            last;
		logic [1:0]      err;
	} cmd_t;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_ESC  = 2'd1;
	localparam logic [1:0] ERR_HEX  = 2'd2;

	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_U      = 8'h75;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// Decoder front end: accepts input bytes, tracks escape state, issues output commands.
`default_nettype none

module jsu_front import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	input  logic q_full,
	output logic cmd_push,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_HEX  = 2'd2
	} mode_t;

	mode_t       mode_q, mode_n;
	logic [1:0]  hex_cnt_q, hex_cnt_n;
	logic [15:0] acc_q, acc_n;
	logic        err_q, err_n;
	logic        accept;
	logic        gen;
	logic [4:0]  hv;
	logic [15:0] cp;

	// Bit 4 set marks a character that is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
		return r;
	endfunction

	// Bit 8 set marks an unknown escape letter.
	function automatic logic [8:0] escape_equiv(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h62:   r = 9'h008;
			8'h66:   r = 9'h00C;
			8'h6E:   r = 9'h00A;
			8'h72:   r = 9'h00D;
			8'h74:   r = 9'h009;
			8'h22:   r = 9'h022;
			8'h5C:   r = 9'h05C;
			8'h2F:   r = 9'h02F;
			default: r = 9'h100;
		endcase
		return r;
	endfunction

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign cmd_push = accept && gen;
	assign hv       = hex_value(item.in_byte);
	assign cp       = {acc_q[11:0], hv[3:0]};

	always_comb begin
		logic [8:0] eq;
		eq        = escape_equiv(item.in_byte);
		gen       = 1'b0;
		cmd       = '0;
		cmd.cnt   = 2'd1;
		cmd.last  = item.last_byte;
		mode_n    = mode_q;
		hex_cnt_n = hex_cnt_q;
		acc_n     = acc_q;
		err_n     = err_q;

		if (err_q) begin
			if (item.last_byte) begin
				gen      = 1'b1;
				mode_n   = MODE_TEXT;
				hex_cnt_n = 2'd0;
				acc_n    = '0;
				err_n    = 1'b0;
			end
		end else if (!item.has_byte) begin
			if (item.last_byte) begin
				gen = 1'b1;
				case (mode_q)
					MODE_ESC: cmd.err = ERR_ESC;
					MODE_HEX: cmd.err = ERR_HEX;
					default:  cmd.err = ERR_NONE;
				endcase
				mode_n    = MODE_TEXT;
				hex_cnt_n = 2'd0;
				acc_n     = '0;
			end
		end else begin
			case (mode_q)
				MODE_ESC: begin
					if (item.in_byte == CHAR_U) begin
						if (item.last_byte) begin
							gen     = 1'b1;
							cmd.err = ERR_HEX;
						end else begin
							mode_n    = MODE_HEX;
							hex_cnt_n = 2'd0;
							acc_n     = '0;
						end
					end else if (!eq[8]) begin
						gen          = 1'b1;
						cmd.vld      = 1'b1;
						cmd.bytes[0] = eq[7:0];
						mode_n       = MODE_TEXT;
					end else begin
						gen     = 1'b1;
						cmd.err = ERR_ESC;
					end
				end
				MODE_HEX: begin
					if (hv[4]) begin
						gen     = 1'b1;
						cmd.err = ERR_HEX;
					end else if (hex_cnt_q != 2'd3) begin
						if (item.last_byte) begin
							gen     = 1'b1;
							cmd.err = ERR_HEX;
						end else begin
							acc_n     = cp;
							hex_cnt_n = 2'(hex_cnt_q + 2'd1);
						end
					end else begin
						gen     = 1'b1;
						cmd.vld = 1'b1;
						if (cp < 16'h0080) begin
							cmd.bytes[0] = cp[7:0];
						end else if (cp < 16'h0800) begin
							cmd.cnt      = 2'd2;
							cmd.bytes[0] = {3'b110, cp[10:6]};
							cmd.bytes[1] = {2'b10, cp[5:0]};
						end else begin
							cmd.cnt      = 2'd3;
							cmd.bytes[0] = {4'b1110, cp[15:12]};
							cmd.bytes[1] = {2'b10, cp[11:6]};
							cmd.bytes[2] = {2'b10, cp[5:0]};
						end
						mode_n    = MODE_TEXT;
						hex_cnt_n = 2'd0;
						acc_n     = '0;
					end
				end
				default: begin
					if (item.in_byte == CHAR_BSLASH) begin
						if (item.last_byte) begin
							gen     = 1'b1;
							cmd.err = ERR_ESC;
						end else begin
							mode_n = MODE_ESC;
						end
					end else begin
						gen          = 1'b1;
						cmd.vld      = 1'b1;
						cmd.bytes[0] = item.in_byte;
						mode_n       = MODE_TEXT;
					end
				end
			endcase

			// Any error clears the escape state; dropping continues unless this was the end.
			if (cmd.err != ERR_NONE) begin
				mode_n    = MODE_TEXT;
				hex_cnt_n = 2'd0;
				acc_n     = '0;
				err_n     = !item.last_byte;
			end else if (gen && item.last_byte) begin
				mode_n    = MODE_TEXT;
				hex_cnt_n = 2'd0;
				acc_n     = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TEXT;
			hex_cnt_q <= 2'd0;
			acc_q     <= '0;
			err_q     <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_n;
			hex_cnt_q <= hex_cnt_n;
			acc_q     <= acc_n;
			err_q     <= err_n;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/jsu_cmdq.sv -----
// Short command queue between the decoder and the output side.
`default_nettype none

module jsu_cmdq import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	cmd_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QCW-1:0]   count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == QCW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= QAW'(wptr_q + 1'b1);
			if (do_rd) rptr_q <= QAW'(rptr_q + 1'b1);
			if (do_wr && !do_rd) count_q <= QCW'(count_q + 1'b1);
			else if (do_rd && !do_wr) count_q <= QCW'(count_q - 1'b1);
		end
	end

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// Output side: expands each command into result beats behind an output register.
`default_nettype none

module jsu_back import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t head,
	input  logic q_empty,
	output logic q_pop,
	output logic empty,
	input  logic pop,
	output out_t result
);

	logic [1:0] idx_q;
	logic       res_vld_q;
	out_t       res_q;
	logic       load;
	logic       final_beat;

	assign load       = !q_empty && (!res_vld_q || pop);
	assign final_beat = (idx_q == 2'(head.cnt - 2'd1));
	assign q_pop      = load && final_beat;
	assign empty      = !res_vld_q;
	assign result     = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte   <= head.bytes[idx_q];
			res_q.out_valid  <= head.vld;
			res_q.out_last   <= head.last && final_beat;
			res_q.error_code <= head.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= 2'd0;
			res_vld_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q     <= final_beat ? 2'd0 : 2'(idx_q + 2'd1);
				res_vld_q <= 1'b1;
			end else if (pop) begin
				res_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_utf8_unit.sv -----
// Top level of the JSON string unescape unit with UTF-8 output.
`default_nettype none

// Takes one byte of a JSON string body per beat and returns the unescaped UTF-8
// bytes in order. A new input beat is accepted every cycle while full is low; a
// plain byte or simple escape yields one result, the fourth hex digit of a \u
// escape yields one to three, and end marks or errors yield a byte-less result.
// Results leave through an output register at one beat per cycle, so the input
// sustains one beat per cycle except when three-byte encodings pile up; a
// four-entry command queue between the decoder and the output register absorbs
// that and any stall on the result side, and full rises only when it is
// exhausted. A result goes through a queue entry and then the output register.
module json_string_unescape_utf8_unit import jsu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic empty,
	input  logic pop,
	output out_t result
);

	logic cmd_push;
	cmd_t cmd;
	logic q_full;
	logic q_empty;
	logic q_pop;
	cmd_t head;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.q_full   (q_full),
		.cmd_push (cmd_push),
		.cmd      (cmd)
	);

	jsu_cmdq u_cmdq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ----- rtl/jsu_checker.sv -----
// Port-level checks for the JSON string unescape unit, bound to the top level.
`default_nettype none

module jsu_checker import jsu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input out_t result
);

	// A waiting result stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while waiting");

	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.out_valid |-> result.out_byte == 8'h00)
		else $error("byte-less result carries a nonzero byte");

	a_err_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.error_code != ERR_NONE |-> !result.out_valid)
		else $error("error report carries data");

	// A byte-less result is either an error report or an end mark.
	a_nodata_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.out_valid |-> result.out_last || result.error_code != ERR_NONE)
		else $error("byte-less result that is neither error nor end");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.error_code != 2'd3)
		else $error("undefined error code");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (.*);

`default_nettype wire
